[hdl/crcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_pkg
// Shared widths, constants and helpers for the Catmull-Rom curve point block.
// ----------------------------------------------------------------------------
package crcp_pkg;

	localparam int POS_W        = 19;
	localparam int FRAC_W       = 16;
	localparam int SEG_W        = 3;
	localparam int COORD_W      = 16;
	localparam int POINT_W      = 32;
	localparam int REG_COUNT    = 6;
	localparam int CFG_IDX_W    = 3;
	localparam int NUM_POINTS_DEF = 6;
	localparam int NUM_TAPS     = 4;

	// basis weight: signed Q.16, covers -8.0 .. just under +8.0
	localparam int W_W    = 20;
	// coordinate times weight, and the sum of four of them
	localparam int PROD_W = COORD_W + 1 + W_W;
	localparam int SUM_W  = PROD_W + 2;

	typedef logic signed [W_W-1:0]    weight_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [COORD_W-1:0]       coord_t;
	typedef logic [POINT_W-1:0]       point_t;

	localparam weight_t W_K2  = 20'sd2;
	localparam weight_t W_K3  = 20'sd3;
	localparam weight_t W_K4  = 20'sd4;
	localparam weight_t W_K5  = 20'sd5;
	localparam weight_t W_TWO = 20'sd131072;

	// Sum is twice the curve value in Q.16: drop 17 bits, clamp to 0..65535.
	function automatic coord_t settle(input sum_t sum);
		coord_t res;
		if (sum[SUM_W-1]) begin
			res = '0;
		end else if (|sum[SUM_W-2:FRAC_W+1+COORD_W]) begin
			res = '1;
		end else begin
			res = sum[FRAC_W+1 +: COORD_W];
		end
		return res;
	endfunction

endpackage

[hdl/crcp_pos_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_pos_if
// Valid/ready channel that carries one curve position per item.
// ----------------------------------------------------------------------------
interface crcp_pos_if;
	logic                        valid;
	logic                        ready;
	logic [crcp_pkg::POS_W-1:0]  curve_position;

	modport source (output valid, output curve_position, input ready);
	modport sink   (input valid, input curve_position, output ready);
endinterface

[hdl/crcp_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_pix_if
// Valid/ready channel that carries one curve point (x, y) per item.
// ----------------------------------------------------------------------------
interface crcp_pix_if;
	logic              valid;
	logic              ready;
	crcp_pkg::coord_t  x_coord;
	crcp_pkg::coord_t  y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

[hdl/crcp_point_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_point_regs
// Control point registers, written through the configuration port.
// ----------------------------------------------------------------------------
module crcp_point_regs #(
	parameter int NUM_POINTS = crcp_pkg::NUM_POINTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [crcp_pkg::CFG_IDX_W-1:0]   index,
	input  crcp_pkg::point_t                 data,
	output crcp_pkg::point_t [NUM_POINTS-1:0] points
);

	crcp_pkg::point_t [NUM_POINTS-1:0] points_q;

	// writes to registers past the curve's point count are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= '0;
		end else if (wr_en) begin
			for (int i = 0; i < NUM_POINTS; i++) begin
				if (index == crcp_pkg::CFG_IDX_W'(i)) begin
					points_q[i] <= data;
				end
			end
		end
	end

	assign points = points_q;

endmodule

[hdl/crcp_basis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_basis
// Stages 1-3: t^2, t^3, the four basis weights and the neighbor indices.
// ----------------------------------------------------------------------------
module crcp_basis #(
	parameter int NUM_POINTS = crcp_pkg::NUM_POINTS_DEF,
	localparam int IDX_W     = $clog2(NUM_POINTS)
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        in_valid,
	input  logic [crcp_pkg::POS_W-1:0]                  curve_position,
	output logic                                        valid_s3,
	output crcp_pkg::weight_t [crcp_pkg::NUM_TAPS-1:0]  weight_s3,
	output logic [crcp_pkg::NUM_TAPS-1:0][IDX_W-1:0]    idx_s3
);

	localparam int FW = crcp_pkg::FRAC_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_POINTS - 1);

	logic            valid_s1, valid_s2;
	logic [FW-1:0]   f_s1, f_s2, t2_s1, t2_s2, t3_s2;
	logic [IDX_W-1:0] seg_s1, seg_s2;

	logic [crcp_pkg::SEG_W:0] seg_raw;
	logic [IDX_W-1:0]         seg_mod;
	logic [2*FW-1:0]          sq, cube;
	crcp_pkg::weight_t        fe, t2e, t3e;
	logic [IDX_W-1:0]         p0, p2, p3;

	// segment index wraps once: it is below twice the point count
	always_comb begin
		seg_raw = {1'b0, curve_position[crcp_pkg::POS_W-1:FW]};
		if (seg_raw >= (crcp_pkg::SEG_W + 1)'(NUM_POINTS)) begin
			seg_mod = IDX_W'(seg_raw - (crcp_pkg::SEG_W + 1)'(NUM_POINTS));
		end else begin
			seg_mod = IDX_W'(seg_raw);
		end
	end

	assign sq   = curve_position[FW-1:0] * curve_position[FW-1:0];
	assign cube = t2_s1 * f_s1;

	assign fe  = crcp_pkg::weight_t'({{(crcp_pkg::W_W-FW){1'b0}}, f_s2});
	assign t2e = crcp_pkg::weight_t'({{(crcp_pkg::W_W-FW){1'b0}}, t2_s2});
	assign t3e = crcp_pkg::weight_t'({{(crcp_pkg::W_W-FW){1'b0}}, t3_s2});

	assign p0 = (seg_s2 == '0)   ? LAST : seg_s2 - 1'b1;
	assign p2 = (seg_s2 == LAST) ? '0   : seg_s2 + 1'b1;
	assign p3 = (p2 == LAST)     ? '0   : p2 + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= curve_position[FW-1:0];
			t2_s1  <= sq[2*FW-1:FW];
			seg_s1 <= seg_mod;

			f_s2   <= f_s1;
			t2_s2  <= t2_s1;
			t3_s2  <= cube[2*FW-1:FW];
			seg_s2 <= seg_s1;

			weight_s3[0] <= crcp_pkg::W_K2 * t2e - t3e - fe;
			weight_s3[1] <= crcp_pkg::W_K3 * t3e - crcp_pkg::W_K5 * t2e + crcp_pkg::W_TWO;
			weight_s3[2] <= crcp_pkg::W_K4 * t2e - crcp_pkg::W_K3 * t3e + fe;
			weight_s3[3] <= t3e - t2e;
			idx_s3[0]    <= p0;
			idx_s3[1]    <= seg_s2;
			idx_s3[2]    <= p2;
			idx_s3[3]    <= p3;
		end
	end

endmodule

[hdl/crcp_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_blend
// Stages 4-6: fetch the four points, weight them, add, scale and clamp.
// ----------------------------------------------------------------------------
module crcp_blend #(
	parameter int NUM_POINTS = crcp_pkg::NUM_POINTS_DEF,
	localparam int IDX_W     = $clog2(NUM_POINTS)
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        valid_s3,
	input  crcp_pkg::weight_t [crcp_pkg::NUM_TAPS-1:0]  weight_s3,
	input  logic [crcp_pkg::NUM_TAPS-1:0][IDX_W-1:0]    idx_s3,
	input  crcp_pkg::point_t [NUM_POINTS-1:0]           points,
	output logic                                        valid_s6,
	output crcp_pkg::coord_t                            x_s6,
	output crcp_pkg::coord_t                            y_s6
);

	localparam int CW = crcp_pkg::COORD_W;
	localparam int NT = crcp_pkg::NUM_TAPS;

	logic valid_s4, valid_s5;

	crcp_pkg::point_t [NT-1:0] pt_sel;
	crcp_pkg::prod_t  [NT-1:0] px_s4, py_s4;
	crcp_pkg::sum_t   [1:0]    sx_s5, sy_s5;
	crcp_pkg::sum_t            sum_x, sum_y;

	always_comb begin
		for (int k = 0; k < NT; k++) begin
			pt_sel[k] = points[idx_s3[k]];
		end
	end

	assign sum_x = sx_s5[0] + sx_s5[1];
	assign sum_y = sy_s5[0] + sy_s5[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NT; k++) begin
				px_s4[k] <= $signed({1'b0, pt_sel[k][CW-1:0]}) * $signed(weight_s3[k]);
				py_s4[k] <= $signed({1'b0, pt_sel[k][2*CW-1:CW]}) * $signed(weight_s3[k]);
			end
			for (int j = 0; j < 2; j++) begin
				sx_s5[j] <= crcp_pkg::SUM_W'($signed(px_s4[2*j]))
					+ crcp_pkg::SUM_W'($signed(px_s4[2*j+1]));
				sy_s5[j] <= crcp_pkg::SUM_W'($signed(py_s4[2*j]))
					+ crcp_pkg::SUM_W'($signed(py_s4[2*j+1]));
			end
			x_s6 <= crcp_pkg::settle(sum_x);
			y_s6 <= crcp_pkg::settle(sum_y);
		end
	end

endmodule

[hdl/catmull_rom_closed_curve_point.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_closed_curve_point
// Uniform Catmull-Rom point on a closed loop of control points.
//
//   channel   dir   payload                    handshake
//   pos       in    curve_position[18:0]       valid / ready
//   pix       out   x_coord[15:0], y_coord     valid / ready
//   cfg_*     in    cfg_index, cfg_data[31:0]  cfg_wr_en, no back-pressure
//
// One item per cycle unless the result stalls; stages: t^2 and t^3 multiplies,
// weights, point multiplies, two adder levels with clamp.
// Reset clears all valid bits and the control points.
// A stalled result freezes the whole pipeline; pos.ready stays high
// whenever the result register is empty or being taken.
// ----------------------------------------------------------------------------
module catmull_rom_closed_curve_point #(
	parameter int NUM_POINTS = crcp_pkg::NUM_POINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	crcp_pos_if.sink                        pos,
	crcp_pix_if.source                      pix,
	input  logic                            cfg_wr_en,
	input  logic [crcp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  crcp_pkg::point_t                cfg_data
);

	localparam int IDX_W = $clog2(NUM_POINTS);

	logic                                       en;
	logic                                       valid_s3;
	logic                                       valid_s6;
	crcp_pkg::weight_t [crcp_pkg::NUM_TAPS-1:0] weight_s3;
	logic [crcp_pkg::NUM_TAPS-1:0][IDX_W-1:0]   idx_s3;
	crcp_pkg::point_t [NUM_POINTS-1:0]          points;
	crcp_pkg::coord_t                           x_s6, y_s6;

	assign en        = !valid_s6 || pix.ready;
	assign pos.ready = en;

	crcp_point_regs #(.NUM_POINTS(NUM_POINTS)) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.points (points)
	);

	crcp_basis #(.NUM_POINTS(NUM_POINTS)) u_basis (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (pos.valid),
		.curve_position (pos.curve_position),
		.valid_s3       (valid_s3),
		.weight_s3      (weight_s3),
		.idx_s3         (idx_s3)
	);

	crcp_blend #(.NUM_POINTS(NUM_POINTS)) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_s3  (valid_s3),
		.weight_s3 (weight_s3),
		.idx_s3    (idx_s3),
		.points    (points),
		.valid_s6  (valid_s6),
		.x_s6      (x_s6),
		.y_s6      (y_s6)
	);

	assign pix.valid   = valid_s6;
	assign pix.x_coord = x_s6;
	assign pix.y_coord = y_s6;

endmodule

[hdl/crcp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcp_checker
// Port-level checks on the curve point block: stall, latency and back-pressure.
// ----------------------------------------------------------------------------
module crcp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input crcp_pkg::coord_t  x_coord,
	input crcp_pkg::coord_t  y_coord
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_coord) && $stable(y_coord))
		else $error("result changed while stalled");

	// an accepted item reaches the output while the sink keeps taking items
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready
		##1 out_ready ##1 out_ready |=> out_valid)
		else $error("item did not arrive after six cycles");

	// full pipeline only stalls behind a waiting result
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while output stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

endmodule

bind catmull_rom_closed_curve_point crcp_checker u_crcp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pos.valid),
	.in_ready  (pos.ready),
	.out_valid (pix.valid),
	.out_ready (pix.ready),
	.x_coord   (pix.x_coord),
	.y_coord   (pix.y_coord)
);

[verif/catmull_rom_closed_curve_point_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_closed_curve_point_test
// Self-checking bench for the closed-loop Catmull-Rom point block. A short
// table of positions runs first: after reset, with all points at full scale,
// and with points shaped for overshoot and negative sums. Out-of-range
// register writes are also covered there. Random positions follow under
// several point sets and idle patterns. Every point is compared with a table
// value or an integer model of the spline.
// ----------------------------------------------------------------------------
module catmull_rom_closed_curve_point_test;

	localparam int CLK_PERIOD       = 20;
	localparam int LOOP_POINTS      = crcp_pkg::NUM_POINTS_DEF;
	localparam int IDX_SPAN         = 1 << crcp_pkg::CFG_IDX_W;
	localparam int N_DIRECTED       = 20;
	localparam int RANDOM_PHASES    = 6;
	localparam int RANDOM_PER_PHASE = 200;
	localparam int PIPE_LATENCY     = 6;
	localparam int CYCLE_LIMIT      = 200000;

	typedef struct packed {
		crcp_pkg::coord_t x;
		crcp_pkg::coord_t y;
	} coord_pair_t;

	typedef enum logic [1:0] {
		ST_RESET,
		ST_ALL_ONES,
		ST_SHAPED,
		ST_SPARE_WRITES
	} dir_stage_t;

	typedef struct packed {
		dir_stage_t                  stage;
		logic [crcp_pkg::POS_W-1:0]  pos;
		logic                        typed;
		coord_pair_t                 pt;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [crcp_pkg::CFG_IDX_W-1:0] cfg_index;
	crcp_pkg::point_t cfg_data;

	crcp_pos_if pos_ch();
	crcp_pix_if pix_ch();

	crcp_pkg::point_t ctl_points [crcp_pkg::REG_COUNT];
	crcp_pkg::point_t reg_image [IDX_SPAN];
	dir_row_t directed_rows [N_DIRECTED];
	coord_pair_t curve_points_due [$];
	int src_idle_pct;
	int snk_idle_pct;
	int mismatches;
	int cycle_count;

	catmull_rom_closed_curve_point #(
		.NUM_POINTS(LOOP_POINTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pos(pos_ch),
		.pix(pix_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// sum is twice the curve value in Q.16
	function automatic crcp_pkg::coord_t clamp_coord(input longint s);
		if (s < 0) begin
			return '0;
		end
		if ((s >>> (crcp_pkg::FRAC_W + 1)) > 65535) begin
			return '1;
		end
		return crcp_pkg::coord_t'(s >>> (crcp_pkg::FRAC_W + 1));
	endfunction

	function automatic coord_pair_t predict_point(input logic [crcp_pkg::POS_W-1:0] p);
		longint frac, sq, cube, acc_x, acc_y;
		longint wt [crcp_pkg::NUM_TAPS];
		int tap [crcp_pkg::NUM_TAPS];
		int seg;
		coord_pair_t r;
		frac = longint'(p[crcp_pkg::FRAC_W-1:0]);
		seg = int'(p[crcp_pkg::POS_W-1:crcp_pkg::FRAC_W]) % LOOP_POINTS;
		sq = (frac * frac) >>> crcp_pkg::FRAC_W;
		cube = (sq * frac) >>> crcp_pkg::FRAC_W;
		wt[0] = -cube + 2 * sq - frac;
		wt[1] = 3 * cube - 5 * sq + 131072;
		wt[2] = -3 * cube + 4 * sq + frac;
		wt[3] = cube - sq;
		tap[1] = seg;
		tap[2] = (seg + 1) % LOOP_POINTS;
		tap[3] = (seg + 2) % LOOP_POINTS;
		tap[0] = (seg == 0) ? LOOP_POINTS - 1 : seg - 1;
		acc_x = 0;
		acc_y = 0;
		for (int k = 0; k < crcp_pkg::NUM_TAPS; k++) begin
			acc_x += longint'(ctl_points[tap[k]][15:0]) * wt[k];
			acc_y += longint'(ctl_points[tap[k]][31:16]) * wt[k];
		end
		r.x = clamp_coord(acc_x);
		r.y = clamp_coord(acc_y);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// writes every index, the spare ones past the point registers included
	task automatic write_registers();
		for (int i = 0; i < IDX_SPAN; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= crcp_pkg::CFG_IDX_W'(i);
			cfg_data <= reg_image[i];
			if (i < crcp_pkg::REG_COUNT) begin
				ctl_points[i] = reg_image[i];
			end
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drain();
		pos_ch.valid <= 1'b0;
		do @(negedge clk); while (curve_points_due.size() != 0);
	endtask

	// called and returns at a falling edge; valid stays high into the next item
	task automatic send_position(input logic [crcp_pkg::POS_W-1:0] p, input bit typed,
			input coord_pair_t typed_pt);
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			pos_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pos_ch.valid <= 1'b1;
		pos_ch.curve_position <= p;
		do @(posedge clk); while (!pos_ch.ready);
		curve_points_due.push_back(typed ? typed_pt : predict_point(p));
		@(negedge clk);
	endtask

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d points outstanding",
					cycle_count, curve_points_due.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		pix_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			pix_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		coord_pair_t want;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			if (curve_points_due.size() == 0) begin
				report_mismatch($sformatf("unexpected point x=%h y=%h",
					pix_ch.x_coord, pix_ch.y_coord));
			end else begin
				want = curve_points_due.pop_front();
				if (pix_ch.x_coord !== want.x) begin
					report_mismatch($sformatf("x_coord %h, want %h",
						pix_ch.x_coord, want.x));
				end
				if (pix_ch.y_coord !== want.y) begin
					report_mismatch($sformatf("y_coord %h, want %h",
						pix_ch.y_coord, want.y));
				end
			end
		end
	end

	initial begin
		logic [crcp_pkg::POS_W-1:0] p;
		dir_stage_t prev_stage;
		arst_n = 1'b0;
		pos_ch.valid = 1'b0;
		pos_ch.curve_position = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		mismatches = 0;
		foreach (ctl_points[i]) ctl_points[i] = '0;
		foreach (reg_image[i]) reg_image[i] = '0;

		// shaped set: x runs 0,max,max,0 and y max,0,0,max over points 0..3,
		// so mid segment 1 overshoots in x and goes negative in y
		directed_rows = '{
			'{ST_RESET,        19'h00000, 1'b1, '{16'h0000, 16'h0000}},
			'{ST_RESET,        19'h7FFFF, 1'b1, '{16'h0000, 16'h0000}},
			'{ST_RESET,        19'h58000, 1'b1, '{16'h0000, 16'h0000}},
			'{ST_ALL_ONES,     19'h00000, 1'b1, '{16'hFFFF, 16'hFFFF}},
			'{ST_ALL_ONES,     19'h28000, 1'b1, '{16'hFFFF, 16'hFFFF}},
			'{ST_ALL_ONES,     19'h5FFFF, 1'b1, '{16'hFFFF, 16'hFFFF}},
			'{ST_ALL_ONES,     19'h60001, 1'b0, '{16'h0000, 16'h0000}},
			'{ST_SHAPED,       19'h10000, 1'b1, '{16'hFFFF, 16'h0000}},
			'{ST_SHAPED,       19'h18000, 1'b1, '{16'hFFFF, 16'h0000}},
			'{ST_SHAPED,       19'h00000, 1'b1, '{16'h0000, 16'hFFFF}},
			'{ST_SHAPED,       19'h50000, 1'b1, '{16'h7FFF, 16'h8000}},
			'{ST_SHAPED,       19'h60000, 1'b1, '{16'h0000, 16'hFFFF}},
			'{ST_SHAPED,       19'h70000, 1'b1, '{16'hFFFF, 16'h0000}},
			'{ST_SHAPED,       19'h4FFFF, 1'b0, '{16'h0000, 16'h0000}},
			'{ST_SHAPED,       19'h50001, 1'b0, '{16'h0000, 16'h0000}},
			'{ST_SHAPED,       19'h04000, 1'b0, '{16'h0000, 16'h0000}},
			'{ST_SHAPED,       19'h3C000, 1'b0, '{16'h0000, 16'h0000}},
			'{ST_SHAPED,       19'h7C000, 1'b0, '{16'h0000, 16'h0000}},
			'{ST_SPARE_WRITES, 19'h00000, 1'b1, '{16'h0000, 16'hFFFF}},
			'{ST_SPARE_WRITES, 19'h50000, 1'b1, '{16'h7FFF, 16'h8000}}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 28;
		snk_idle_pct = 73;
		prev_stage = ST_RESET;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].stage != prev_stage) begin
				wait_drain();
				case (directed_rows[i].stage)
					ST_ALL_ONES: begin
						foreach (reg_image[r]) reg_image[r] = '1;
					end
					ST_SHAPED: begin
						reg_image[0] = 32'hFFFF_0000;
						reg_image[1] = 32'h0000_FFFF;
						reg_image[2] = 32'h0000_FFFF;
						reg_image[3] = 32'hFFFF_0000;
						reg_image[4] = 32'h1234_ABCD;
						reg_image[5] = 32'h8000_7FFF;
						reg_image[6] = '0;
						reg_image[7] = '0;
					end
					ST_SPARE_WRITES: begin
						// points unchanged, junk only to the spare indexes
						reg_image[6] = 32'hFFFF_FFFF;
						reg_image[7] = 32'h5555_AAAA;
					end
					default: begin
					end
				endcase
				write_registers();
				prev_stage = directed_rows[i].stage;
			end
			send_position(directed_rows[i].pos, directed_rows[i].typed,
				directed_rows[i].pt);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drain();
			src_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 73 : 0;
			snk_idle_pct = (ph < 2) ? 73 : (ph < 4) ? 28 : 0;
			for (int r = 0; r < IDX_SPAN; r++) begin
				case (ph % 3)
					0: reg_image[r] = $urandom;
					1: reg_image[r] = {($urandom_range(0, 1) ? 16'hFFFF : 16'h0000),
						($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
					default: reg_image[r] = {16'($urandom_range(0, 1023)),
						16'($urandom_range(64512, 65535))};
				endcase
			end
			write_registers();
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (ph == 0 && n == RANDOM_PER_PHASE / 2) begin
					wait_drain();
				end
				p = crcp_pkg::POS_W'($urandom_range(0, (1 << crcp_pkg::POS_W) - 1));
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 3))
						0: p[crcp_pkg::FRAC_W-1:0] = '0;
						1: p[crcp_pkg::FRAC_W-1:0] = 16'h0001;
						2: p[crcp_pkg::FRAC_W-1:0] = 16'h8000;
						default: p[crcp_pkg::FRAC_W-1:0] = '1;
					endcase
				end
				send_position(p, 1'b0, '0);
			end
		end

		wait_drain();
		repeat (PIPE_LATENCY + 4) @(negedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[files.f]
hdl/crcp_pkg.sv
hdl/crcp_pos_if.sv
hdl/crcp_pix_if.sv
hdl/crcp_point_regs.sv
hdl/crcp_basis.sv
hdl/crcp_blend.sv
hdl/catmull_rom_closed_curve_point.sv
hdl/crcp_checker.sv
verif/catmull_rom_closed_curve_point_test.sv
